/* hdl/tsb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsb_pkg;

    // field widths
    localparam int TEX_W  = 32;
    localparam int SLOT_W = 5;
    localparam int SIZE_W = 11;
    localparam int TU_W   = 6;

    // texture unit count after reset
    localparam logic [TU_W-1:0] TU_RESET = 6'd16;

    // result kinds
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_BIND   = 1'b1;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;   // register the compare result of the incoming word
        logic load;      // write the new texture id into this cell
        logic shift;     // take the id of the right-hand neighbor
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/tsb_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsb_cell
    import tsb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic             enable,
    input  wire logic [TEX_W-1:0] key,
    input  wire logic [TEX_W-1:0] load_id,
    input  wire logic [TEX_W-1:0] next_id,
    output logic      [TEX_W-1:0] id,
    output logic                  hit
);

    logic [TEX_W-1:0] id_reg;
    logic [TEX_W-1:0] id_next;
    logic             hit_reg;
    logic             hit_next;

    // compare the key against the held id while this cell is in use
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.capture)
        begin
            hit_next = enable && (id_reg == key);
        end
    end

    // load a new id or advance the chain toward cell zero
    always_comb
    begin
        id_next = id_reg;
        if (ctrl.load)
        begin
            id_next = load_id;
        end
        else if (ctrl.shift)
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    // id storage carries no reset
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id  = id_reg;
    assign hit = hit_reg;

endmodule

`default_nettype wire

/* hdl/texture_slot_batcher.sv */
`timescale 1ns / 1ps
`default_nettype none

// An accepted input word is compared in the cell row; the sequencer then enters ASSIGN,
// which registers the assignment result once the output register is free. The block
// takes no new word until it is back in IDLE; a flush adds one bind word per used slot
// while the ids shift out of cell zero. Output stalls hold ASSIGN and DRAIN.
// Reset clears the counters, the sequencer and the output valid flag and sets
// texture_units to 16; the slot table contents stay undefined until written.
module texture_slot_batcher
    import tsb_pkg::*;
#(
    parameter int MAX_SLOTS = 32,
    parameter int MAX_BATCH = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TU_W-1:0]   cfg_data,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [TEX_W-1:0]  texture_id,
    input  wire logic              group_last,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   result_kind,
    output logic [SLOT_W-1:0]      sampler_slot,
    output logic [TEX_W-1:0]       bound_texture,
    output logic                   flush,
    output logic [SIZE_W-1:0]      batch_size,
    output logic                   last
);

    localparam int SW  = $clog2(MAX_SLOTS + 1);
    localparam int IW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW  = (SW > TU_W) ? SW : TU_W;
    localparam int BW  = $clog2(MAX_BATCH + 1);
    localparam int BXW = (BW > SIZE_W) ? BW : SIZE_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ASSIGN = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [TU_W-1:0]   units_reg;
    logic [SW-1:0]     used_reg;
    logic [SW-1:0]     used_next;
    logic [BW-1:0]     inst_reg;
    logic [BW-1:0]     inst_next;
    logic [SW-1:0]     bind_idx_reg;
    logic [SW-1:0]     bind_idx_next;
    logic [TEX_W-1:0]  tex_reg;
    logic              glast_reg;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TEX_W-1:0]  bound_reg;
    logic              flush_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              last_reg;

    logic              in_accept;
    logic              out_free;
    logic              assign_go;
    logic              drain_go;
    logic              hit_any;
    logic [IW-1:0]     hit_idx;
    logic [SW-1:0]     used_upd;
    logic [BW-1:0]     inst_upd;
    logic [CW-1:0]     slot_sel;
    logic [CW-1:0]     bind_slot;
    logic [BXW-1:0]    size_wide;
    logic              do_flush;
    logic              drain_end;

    logic [TEX_W-1:0]     cell_id  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] cell_hit;
    logic [MAX_SLOTS-1:0] cell_en;
    cell_ctrl_t           cell_ctrl [MAX_SLOTS];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign assign_go = (state_reg == ST_ASSIGN) && out_free;
    assign drain_go  = (state_reg == ST_DRAIN) && out_free;

    // row of slot cells
    for (genvar g = 0; g < MAX_SLOTS; g++)
    begin : g_cell
        localparam logic [SW-1:0] IDX = SW'(g);
        logic [TEX_W-1:0] right_id;

        if (g == MAX_SLOTS - 1)
        begin : g_end
            assign right_id = '0;
        end
        else
        begin : g_mid
            assign right_id = cell_id[g + 1];
        end

        assign cell_en[g]           = (IDX < used_reg);
        assign cell_ctrl[g].capture = in_accept;
        assign cell_ctrl[g].load    = assign_go && !hit_any && (used_reg == IDX);
        assign cell_ctrl[g].shift   = drain_go;

        tsb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl[g]),
            .enable  (cell_en[g]),
            .key     (texture_id),
            .load_id (tex_reg),
            .next_id (right_id),
            .id      (cell_id[g]),
            .hit     (cell_hit[g])
        );
    end

    // encode the matching cell; ids in the row are distinct
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (cell_hit[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end
    assign hit_any = |cell_hit;

    // slot choice, counter update and flush decision
    always_comb
    begin
        slot_sel = hit_any ? CW'(hit_idx) : CW'(used_reg);
        used_upd = used_reg;
        if (!hit_any && (used_reg < SW'(MAX_SLOTS)))
        begin
            used_upd = used_reg + SW'(1);
        end
        inst_upd  = inst_reg + BW'(1);
        size_wide = BXW'(inst_upd);
        do_flush  = (inst_upd >= BW'(MAX_BATCH)) || glast_reg ||
                    (CW'(used_upd) >= CW'(units_reg)) ||
                    (used_upd >= SW'(MAX_SLOTS));
        bind_slot = CW'(bind_idx_reg);
        drain_end = ((bind_idx_reg + SW'(1)) == used_reg);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        inst_next     = inst_reg;
        bind_idx_next = bind_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN:
            begin
                if (assign_go)
                begin
                    used_next     = used_upd;
                    bind_idx_next = '0;
                    if (do_flush)
                    begin
                        inst_next  = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        inst_next  = inst_upd;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_go)
                begin
                    bind_idx_next = bind_idx_reg + SW'(1);
                    if (drain_end)
                    begin
                        used_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            inst_reg      <= '0;
            bind_idx_reg  <= '0;
            units_reg     <= TU_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            inst_reg     <= inst_next;
            bind_idx_reg <= bind_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                units_reg <= cfg_data;
            end
            if (assign_go || drain_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the accepted word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tex_reg   <= texture_id;
            glast_reg <= group_last;
        end
    end

    // load the output word
    always_ff @(posedge clk)
    begin
        if (assign_go)
        begin
            kind_reg  <= KIND_ASSIGN;
            slot_reg  <= slot_sel[SLOT_W-1:0];
            bound_reg <= '0;
            flush_reg <= do_flush;
            size_reg  <= do_flush ? size_wide[SIZE_W-1:0] : '0;
            last_reg  <= !do_flush || (used_upd == '0);
        end
        else if (drain_go)
        begin
            kind_reg  <= KIND_BIND;
            slot_reg  <= bind_slot[SLOT_W-1:0];
            bound_reg <= cell_id[0];
            flush_reg <= 1'b0;
            size_reg  <= '0;
            last_reg  <= drain_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign sampler_slot  = slot_reg;
    assign bound_texture = bound_reg;
    assign flush         = flush_reg;
    assign batch_size    = size_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

/* test/texture_slot_batcher_test.sv */
`timescale 1ns / 1ps

module texture_slot_batcher_test;
    import tsb_pkg::*;

    localparam int MAX_SLOTS   = 32;
    localparam int MAX_BATCH   = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam logic [TU_W-1:0] TU_MAX = 6'd63;

    // one result word as the block should emit it
    typedef struct {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [TEX_W-1:0]  tex;
        logic              flush;
        logic [SIZE_W-1:0] size;
        logic              last;
    } slot_word_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [TU_W-1:0]   cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [TEX_W-1:0]  texture_id;
    logic              group_last;
    logic              out_valid;
    logic              out_stall;
    logic              result_kind;
    logic [SLOT_W-1:0] sampler_slot;
    logic [TEX_W-1:0]  bound_texture;
    logic              flush;
    logic [SIZE_W-1:0] batch_size;
    logic              last;

    // shadow state of the batcher
    logic [TEX_W-1:0]  slot_tex [MAX_SLOTS];
    int                used_slots;
    int                open_count;
    logic [TU_W-1:0]   unit_limit;

    slot_word_t        pending_words [$];
    int                err_cnt;
    int                words_sent;
    int                words_checked;
    int                batches_closed;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_reqs;

    texture_slot_batcher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .texture_id    (texture_id),
        .group_last    (group_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .sampler_slot  (sampler_slot),
        .bound_texture (bound_texture),
        .flush         (flush),
        .batch_size    (batch_size),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // give up after a generous bound
    initial
    begin
        #15_000_000;
        $display("texture_slot_batcher test failed");
        $finish;
    end

    // drive output stall: random, or held for a long stretch on request
    initial
    begin : out_stall_gen
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // predict the words caused by one accepted instance
    task automatic predict_slots(input logic [TEX_W-1:0] tex, input logic grp_end);
        int         slot;
        int         i;
        bit         hit;
        logic       closes;
        slot_word_t w;
        slot = used_slots;
        hit  = 1'b0;
        for (i = 0; i < used_slots; i++)
        begin
            if (!hit && slot_tex[i] == tex)
            begin
                slot = i;
                hit  = 1'b1;
            end
        end
        // take the next free slot for a new id
        if (slot == used_slots && used_slots < MAX_SLOTS)
        begin
            slot_tex[used_slots] = tex;
            used_slots++;
        end
        open_count++;
        closes = (open_count >= MAX_BATCH) || grp_end ||
                 (used_slots >= unit_limit) || (used_slots >= MAX_SLOTS);
        w.kind  = KIND_ASSIGN;
        w.slot  = SLOT_W'(slot);
        w.tex   = '0;
        w.flush = closes;
        w.size  = closes ? SIZE_W'(open_count) : '0;
        w.last  = closes ? (used_slots == 0) : 1'b1;
        pending_words.push_back(w);
        if (closes)
        begin
            // emit binds in slot order, then clear the batch
            for (i = 0; i < used_slots; i++)
            begin
                w.kind  = KIND_BIND;
                w.slot  = SLOT_W'(i);
                w.tex   = slot_tex[i];
                w.flush = 1'b0;
                w.size  = '0;
                w.last  = (i + 1 == used_slots);
                pending_words.push_back(w);
            end
            used_slots = 0;
            open_count = 0;
            batches_closed++;
        end
    endtask

    // offer one instance word, hold it until accepted
    task automatic send_word(input logic [TEX_W-1:0] tex, input logic grp_end);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        texture_id <= tex;
        group_last <= grp_end;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predict_slots(tex, grp_end);
        words_sent++;
    endtask

    // stop offering and wait for every expected word
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // write texture_units once the block is idle
    task automatic write_units(input logic [TU_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid  <= 1'b0;
        unit_limit = value;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic check_field(input string name, input logic [TEX_W-1:0] exp_v,
                               input logic [TEX_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected result word, kind %0h slot %0h tex %0h",
                         $time, result_kind, sampler_slot, bound_texture);
                err_cnt++;
            end
            else
            begin
                slot_word_t w;
                w = pending_words.pop_front();
                check_field("result_kind", TEX_W'(w.kind), TEX_W'(result_kind));
                check_field("sampler_slot", TEX_W'(w.slot), TEX_W'(sampler_slot));
                check_field("bound_texture", w.tex, bound_texture);
                check_field("flush", TEX_W'(w.flush), TEX_W'(flush));
                check_field("batch_size", TEX_W'(w.size), TEX_W'(batch_size));
                check_field("last", TEX_W'(w.last), TEX_W'(last));
                words_checked++;
            end
        end
    end

    // reset default of 16 units, id extremes, reuse and group end
    task automatic test_default_units;
        int i;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        for (i = 0; i < 16; i++)
            send_word(32'h1000_0000 + i, 1'b0);
    endtask

    // zero, one and above-table unit counts
    task automatic test_unit_limits;
        int i;
        write_units(6'd0);
        send_word(32'hA5A5_A5A5, 1'b0);
        send_word(32'hA5A5_A5A5, 1'b1);
        write_units(6'd1);
        send_word(32'h5A5A_5A5A, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        write_units(TU_MAX);
        // fill the whole table: closes at MAX_SLOTS with every bind
        for (i = 0; i < MAX_SLOTS; i++)
            send_word($urandom, 1'b0);
        write_units(6'd32);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
    endtask

    // hold the output off so the block backs up into its input
    task automatic test_output_hold;
        int i;
        write_units(6'd16);
        set_idle(0, 0);
        hold_reqs++;
        for (i = 0; i < 48; i++)
            send_word($urandom_range(0, 7), (i % 6) == 5);
        drain();
    endtask

    // mostly well-formed groups from small id pools, some raw noise
    task automatic test_random_groups(input int send_pct, input int recv_pct, input int n_items);
        int               sent;
        int               len;
        int               pool_n;
        int               k;
        int               seg;
        logic [TEX_W-1:0] pool [6];
        logic [TU_W-1:0]  setting;
        set_idle(send_pct, recv_pct);
        for (seg = 0; seg < 3; seg++)
        begin
            case ($urandom_range(0, 5))
                0: setting = 6'd0;
                1: setting = 6'd1;
                2: setting = 6'd32;
                3: setting = TU_MAX;
                4: setting = TU_RESET;
                default: setting = TU_W'($urandom_range(2, 31));
            endcase
            write_units(setting);
            sent = 0;
            while (sent < n_items / 3)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    len    = $urandom_range(1, 12);
                    pool_n = $urandom_range(1, 6);
                    for (k = 0; k < pool_n; k++)
                    begin
                        case ($urandom_range(0, 7))
                            0: pool[k] = 32'h0000_0000;
                            1: pool[k] = 32'hFFFF_FFFF;
                            default: pool[k] = $urandom;
                        endcase
                    end
                    for (k = 0; k < len; k++)
                        send_word(pool[$urandom_range(0, pool_n - 1)], k == len - 1);
                    sent = sent + len;
                end
                else
                begin
                    send_word($urandom, 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        texture_id = '0;
        group_last = 1'b0;
        used_slots = 0;
        open_count = 0;
        unit_limit = TU_RESET;
        err_cnt    = 0;
        words_sent = 0;
        words_checked  = 0;
        batches_closed = 0;
        hold_reqs  = 0;
        set_idle(36, 75);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_units();
        test_unit_limits();
        test_output_hold();
        test_random_groups(36, 75, 45);
        test_random_groups(75, 36, 45);
        test_random_groups(0, 0, 45);

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d instance words, checked %0d result words over %0d closed batches,",
                 words_sent, words_checked, batches_closed);
        $display("with unit limits 0, 1, 16, 32, 63, group ends and output hold-off.");
        if (err_cnt == 0)
            $display("texture_slot_batcher test passed");
        else
            $display("texture_slot_batcher test failed");
        $finish;
    end

endmodule
